>>> hdl/dspsmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspsmp_pkg
// Shared types and codes of the dsp status message parser.
// ----------------------------------------------------------------------------
package dspsmp_pkg;

  // item opcodes (tuser on the input side)
  localparam logic [1:0] OP_PARSE      = 2'd0;
  localparam logic [1:0] OP_READ_METER = 2'd1;
  localparam logic [1:0] OP_READ_PARAM = 2'd2;

  // message types, bits 7..3 of the flag byte
  localparam logic [4:0] TYPE_MIXER   = 5'h01;
  localparam logic [4:0] TYPE_GAIN    = 5'h02;
  localparam logic [4:0] TYPE_PAN     = 5'h03;
  localparam logic [4:0] TYPE_FLAG    = 5'h04;
  localparam logic [4:0] TYPE_BALANCE = 5'h17;
  localparam logic [4:0] TYPE_WIDTH   = 5'h18;
  localparam logic [4:0] TYPE_METER   = 5'h1f;

  // update kinds (tuser on the output side)
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_MIXER = 3'd1;
  localparam logic [2:0] KIND_GAIN  = 3'd2;
  localparam logic [2:0] KIND_METER = 3'd7;

  // parameter tables
  localparam int TABLES = 5;
  localparam logic [2:0] TBL_GAIN    = 3'd0;
  localparam logic [2:0] TBL_PAN     = 3'd1;
  localparam logic [2:0] TBL_FLAG    = 3'd2;
  localparam logic [2:0] TBL_BALANCE = 3'd3;
  localparam logic [2:0] TBL_WIDTH   = 3'd4;

  // meter index mapping
  localparam logic [5:0] METER_BANK_OFFSET = 6'd20;

  typedef struct packed {
    logic       ok;
    logic [2:0] idx;
  } tbl_t;

  typedef struct packed {
    logic       updated;
    logic [2:0] kind;
    logic [1:0] mixer;
    logic [4:0] source;
    logic [5:0] slot;
    logic       dropped;
  } res_t;

  function automatic tbl_t tbl_of_type(input logic [4:0] t);
    tbl_t r;
    r.ok  = 1'b1;
    r.idx = TBL_GAIN;
    unique case (t)
      TYPE_GAIN:    r.idx = TBL_GAIN;
      TYPE_PAN:     r.idx = TBL_PAN;
      TYPE_FLAG:    r.idx = TBL_FLAG;
      TYPE_BALANCE: r.idx = TBL_BALANCE;
      TYPE_WIDTH:   r.idx = TBL_WIDTH;
      default:      r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/dspsmp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspsmp_store
// Byte store with one write port, one registered read port and a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
module dspsmp_store #(
  parameter int DEPTH = 400,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  output logic          busy
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // sweep owns the write port until every entry is zero
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt] <= 8'd0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/dsp_status_message_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_status_message_parser
// Decodes status messages of audio data blocks into mixer parameter and meter
// stores, and answers read items from those stores.
// ----------------------------------------------------------------------------
// One item is taken every cycle unless a store is being cleared or the output
// stalls. Taking an item decodes it against the mixer, source and type
// registers, writes the store and issues the read; the result then passes the
// decode register and the output register, which takes the registered read
// data of the store. Parse items never read a store, so an item that reads
// straight after a write sees the new byte. After reset both stores are swept
// to zero, one entry per cycle each, over max(MIXERS*5*SOURCES, METER_SLOTS)
// entries (400 by default); no item is taken then, configuration writes are.
module dsp_status_message_parser #(
  parameter int MIXERS      = 4,
  parameter int SOURCES     = 20,
  parameter int METER_SLOTS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // meter_index_quirk
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // flag_byte[7:0], value_byte[15:8], byte_six[23:16], byte_seven[31:24],
  // read_table[34:32], read_mixer[36:35], read_source[41:37],
  // read_meter_slot[47:42]
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[7:0], updated[8], update_mixer[10:9], update_source[15:11],
  // update_meter_slot[21:16], index_dropped[22], zero[23]
  output logic [23:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser    // update_kind
);

  localparam int PDEPTH = MIXERS * dspsmp_pkg::TABLES * SOURCES;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int MAW    = (METER_SLOTS > 1) ? $clog2(METER_SLOTS) : 1;

  typedef enum logic [1:0] {RD_NONE, RD_METER, RD_PARAM} rd_sel_t;

  // input fields
  logic [7:0] flag_byte, value_byte, byte_six, byte_seven;
  logic [2:0] read_table;
  logic [1:0] read_mixer, opcode;
  logic [4:0] read_source;
  logic [5:0] read_meter_slot;

  assign flag_byte       = s_axis_tdata[7:0];
  assign value_byte      = s_axis_tdata[15:8];
  assign byte_six        = s_axis_tdata[23:16];
  assign byte_seven      = s_axis_tdata[31:24];
  assign read_table      = s_axis_tdata[34:32];
  assign read_mixer      = s_axis_tdata[36:35];
  assign read_source     = s_axis_tdata[41:37];
  assign read_meter_slot = s_axis_tdata[47:42];
  assign opcode          = s_axis_tuser;

  // control state
  logic       meter_index_quirk;
  logic [4:0] last_type;
  logic       cur_mixer_ok;
  logic [2:0] cur_mixer;
  logic [5:0] cur_source;   // all ones after reset, wraps to zero

  // pipeline
  logic                s1_valid;
  dspsmp_pkg::res_t    s1_res;
  rd_sel_t             s1_rsel;
  logic                out_valid;
  dspsmp_pkg::res_t    out_res;
  logic [7:0]          out_rdata;
  logic                s1_move, in_fire, busy, p_busy, m_busy;

  // decode
  logic [4:0]       mtype;
  dspsmp_pkg::tbl_t tbl;
  logic [5:0]       src_next;
  logic             src_ok;
  logic [2:0]       sel_mixer;
  logic             sel_ok;
  logic [7:0]       meter_pos;
  logic [5:0]       meter_slot;
  logic             slot_ok;
  logic             p_rd_ok, m_rd_ok;

  dspsmp_pkg::res_t res;
  rd_sel_t          rsel;
  logic             p_wr_en, m_wr_en;
  logic [PAW-1:0]   p_wr_addr, p_rd_addr;
  logic [MAW-1:0]   m_wr_addr, m_rd_addr;
  logic [7:0]       p_rd_data, m_rd_data;

  // mixer select state update
  logic       set_mixer, set_source, set_type;

  assign busy          = p_busy || m_busy;
  assign cfg_ready     = 1'b1;
  assign s1_move       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !busy && (!s1_valid || s1_move);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign mtype      = flag_byte[7:3];
  assign tbl        = dspsmp_pkg::tbl_of_type(mtype);
  assign src_next   = (mtype == last_type) ? cur_source + 6'd1 : 6'd0;
  assign src_ok     = int'(src_next) < SOURCES;
  assign sel_mixer  = value_byte[7:5];
  assign sel_ok     = int'(sel_mixer) < MIXERS;
  assign meter_pos  = meter_index_quirk ? byte_six : byte_seven;
  assign meter_slot = meter_pos[7] ? {1'b0, meter_pos[4:0]} + dspsmp_pkg::METER_BANK_OFFSET
                                   : {1'b0, meter_pos[4:0]};
  assign slot_ok    = int'(meter_slot) < METER_SLOTS;
  assign p_rd_ok    = (int'(read_table) < dspsmp_pkg::TABLES) &&
                      (int'(read_mixer) < MIXERS) && (int'(read_source) < SOURCES);
  assign m_rd_ok    = int'(read_meter_slot) < METER_SLOTS;

  assign p_wr_addr = PAW'((int'(cur_mixer) * dspsmp_pkg::TABLES + int'(tbl.idx)) * SOURCES
                          + int'(src_next));
  assign p_rd_addr = PAW'((int'(read_mixer) * dspsmp_pkg::TABLES + int'(read_table)) * SOURCES
                          + int'(read_source));
  assign m_wr_addr = MAW'(meter_slot);
  assign m_rd_addr = MAW'(read_meter_slot);

  always_comb begin
    res        = '0;
    rsel       = RD_NONE;
    p_wr_en    = 1'b0;
    m_wr_en    = 1'b0;
    set_mixer  = 1'b0;
    set_source = 1'b0;
    set_type   = 1'b0;
    case (opcode)
      dspsmp_pkg::OP_PARSE: begin
        if (mtype == dspsmp_pkg::TYPE_MIXER) begin
          res.kind = dspsmp_pkg::KIND_MIXER;
          if (sel_ok) begin
            set_mixer   = 1'b1;
            res.updated = 1'b1;
            res.mixer   = sel_mixer[1:0];
          end else begin
            res.dropped = 1'b1;
          end
        end else if (tbl.ok) begin
          res.kind = dspsmp_pkg::KIND_GAIN + tbl.idx;
          set_type = 1'b1;
          if (cur_mixer_ok && src_ok) begin
            p_wr_en     = 1'b1;
            set_source  = 1'b1;
            res.updated = 1'b1;
            res.mixer   = cur_mixer[1:0];
            res.source  = src_next[4:0];
          end else begin
            res.dropped = 1'b1;
          end
        end else if (mtype == dspsmp_pkg::TYPE_METER) begin
          res.kind = dspsmp_pkg::KIND_METER;
          if (slot_ok) begin
            m_wr_en     = 1'b1;
            res.updated = 1'b1;
            res.slot    = meter_slot;
          end else begin
            res.dropped = 1'b1;
          end
        end
      end
      dspsmp_pkg::OP_READ_METER: begin
        if (m_rd_ok) rsel = RD_METER;
        else res.dropped = 1'b1;
      end
      dspsmp_pkg::OP_READ_PARAM: begin
        if (p_rd_ok) rsel = RD_PARAM;
        else res.dropped = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meter_index_quirk <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      meter_index_quirk <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_type    <= '0;
      cur_mixer_ok <= 1'b0;
      cur_mixer    <= '0;
      cur_source   <= '1;
    end else if (in_fire) begin
      if (set_mixer) begin
        cur_mixer_ok <= 1'b1;
        cur_mixer    <= sel_mixer;
        cur_source   <= '0;
      end
      if (set_type) last_type <= mtype;
      if (set_source) cur_source <= src_next;
    end
  end

  // decode stage, store read data lands alongside it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_res  <= res;
      s1_rsel <= rsel;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      out_res <= s1_res;
      case (s1_rsel)
        RD_METER: out_rdata <= m_rd_data;
        RD_PARAM: out_rdata <= p_rd_data;
        default:  out_rdata <= 8'd0;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.dropped, out_res.slot, out_res.source,
                          out_res.mixer, out_res.updated, out_rdata};
  assign m_axis_tuser  = out_res.kind;

  dspsmp_store #(
    .DEPTH (PDEPTH),
    .AW    (PAW)
  ) u_param_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_fire && p_wr_en),
    .wr_addr (p_wr_addr),
    .wr_data (value_byte),
    .rd_en   (in_fire && (rsel == RD_PARAM)),
    .rd_addr (p_rd_addr),
    .rd_data (p_rd_data),
    .busy    (p_busy)
  );

  dspsmp_store #(
    .DEPTH (METER_SLOTS),
    .AW    (MAW)
  ) u_meter_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_fire && m_wr_en),
    .wr_addr (m_wr_addr),
    .wr_data (value_byte),
    .rd_en   (in_fire && (rsel == RD_METER)),
    .rd_addr (m_rd_addr),
    .rd_data (m_rd_data),
    .busy    (m_busy)
  );

  // nothing can reach the output while the stores are still being cleared
  a_idle_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> (!s1_valid && !out_valid))
    else $error("result pending during store clearing");

  a_update_not_dropped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.updated && out_res.dropped))
    else $error("result both updated and dropped");

  a_read_no_update: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rdata != 8'd0) |-> (!out_res.updated &&
                                          out_res.kind == dspsmp_pkg::KIND_NONE))
    else $error("read data on an update result");

  a_mixer_selected: assert property (@(posedge clk) disable iff (rst)
    (in_fire && set_mixer) |=> (cur_mixer_ok && cur_source == 6'd0))
    else $error("mixer select not taken");

endmodule

>>> bench/dsp_status_message_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_status_message_parser_test
// Stream-level test of the status message parser. A scoreboard keeps its own
// copy of the mixer, source, parameter and meter state and predicts the
// result of every accepted item. It then checks each output item field by
// field in order. Directed items cover the edge cases, then long runs of
// well-formed message sequences, reads and noise follow. Both meter index
// settings are used, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module dsp_status_message_parser_test;

  localparam int NMIX  = 4;
  localparam int NSRC  = 20;
  localparam int NSLOT = 40;

  // opcode 3 is a plain no-op, the package leaves it unnamed
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [4:0] SRC_TYPES [5] = '{dspsmp_pkg::TYPE_GAIN, dspsmp_pkg::TYPE_PAN,
                                           dspsmp_pkg::TYPE_FLAG, dspsmp_pkg::TYPE_BALANCE,
                                           dspsmp_pkg::TYPE_WIDTH};

  // packed so that flag_byte lands in the lowest bits of tdata
  typedef struct packed {
    logic [5:0] rslot;
    logic [4:0] rsrc;
    logic [1:0] rmix;
    logic [2:0] rtab;
    logic [7:0] b7;
    logic [7:0] b6;
    logic [7:0] value;
    logic [7:0] flag;
  } msg_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       upd;
    logic [2:0] kind;
    logic [1:0] mix;
    logic [4:0] src;
    logic [5:0] slot;
    logic       drop;
  } outcome_t;

  class parser_scoreboard;
    bit         quirk;
    logic [4:0] last_type;
    logic [7:0] cur_mixer;
    logic [7:0] cur_source;
    logic [7:0] params [NMIX][dspsmp_pkg::TABLES][NSRC];
    logic [7:0] meters [NSLOT];
    outcome_t   pending_q [$];
    int         errors;
    int         results;
    int         reads;
    int         drops;
    int         updates [8];

    function new();
      quirk      = 1'b0;
      last_type  = 5'd0;
      cur_mixer  = 8'hff;
      cur_source = 8'hff;
      foreach (params[i, j, k]) params[i][j][k] = 8'h00;
      foreach (meters[i]) meters[i] = 8'h00;
      foreach (updates[i]) updates[i] = 0;
      errors  = 0;
      results = 0;
      reads   = 0;
      drops   = 0;
    endfunction

    function void set_quirk(bit q);
      quirk = q;
    endfunction

    function void note_item(logic [1:0] op, msg_t m);
      outcome_t   e;
      logic [4:0] typ;
      logic [7:0] src;
      logic [7:0] pos;
      logic [7:0] slot;
      int         tbl;
      e   = '0;
      typ = m.flag[7:3];
      tbl = -1;
      case (typ)
        dspsmp_pkg::TYPE_GAIN:    tbl = dspsmp_pkg::TBL_GAIN;
        dspsmp_pkg::TYPE_PAN:     tbl = dspsmp_pkg::TBL_PAN;
        dspsmp_pkg::TYPE_FLAG:    tbl = dspsmp_pkg::TBL_FLAG;
        dspsmp_pkg::TYPE_BALANCE: tbl = dspsmp_pkg::TBL_BALANCE;
        dspsmp_pkg::TYPE_WIDTH:   tbl = dspsmp_pkg::TBL_WIDTH;
        default:                  tbl = -1;
      endcase
      if (op == dspsmp_pkg::OP_PARSE) begin
        if (typ == dspsmp_pkg::TYPE_MIXER) begin
          e.kind = dspsmp_pkg::KIND_MIXER;
          if (m.value[7:5] < NMIX) begin
            cur_mixer  = {5'd0, m.value[7:5]};
            cur_source = 8'd0;
            e.upd = 1'b1;
            e.mix = m.value[6:5];
          end else begin
            e.drop = 1'b1;
          end
        end else if (tbl >= 0) begin
          e.kind = dspsmp_pkg::KIND_GAIN + tbl[2:0];
          // a run of one type numbers its sources, any other type restarts at zero
          src = (typ != last_type) ? 8'd0 : cur_source + 8'd1;
          last_type = typ;
          if (cur_mixer < NMIX && src < NSRC) begin
            params[cur_mixer][tbl][src] = m.value;
            cur_source = src;
            e.upd = 1'b1;
            e.mix = cur_mixer[1:0];
            e.src = src[4:0];
          end else begin
            e.drop = 1'b1;
          end
        end else if (typ == dspsmp_pkg::TYPE_METER) begin
          e.kind = dspsmp_pkg::KIND_METER;
          pos  = quirk ? m.b6 : m.b7;
          slot = {3'd0, pos[4:0]};
          if (pos[7])
            slot = slot + {2'd0, dspsmp_pkg::METER_BANK_OFFSET};
          if (slot < NSLOT) begin
            meters[slot] = m.value;
            e.upd  = 1'b1;
            e.slot = slot[5:0];
          end else begin
            e.drop = 1'b1;
          end
        end
      end else if (op == dspsmp_pkg::OP_READ_METER) begin
        reads++;
        if (m.rslot < NSLOT)
          e.rdata = meters[m.rslot];
        else
          e.drop = 1'b1;
      end else if (op == dspsmp_pkg::OP_READ_PARAM) begin
        reads++;
        if (m.rtab < dspsmp_pkg::TABLES && m.rmix < NMIX && m.rsrc < NSRC)
          e.rdata = params[m.rmix][m.rtab][m.rsrc];
        else
          e.drop = 1'b1;
      end
      if (e.upd)
        updates[e.kind]++;
      if (e.drop)
        drops++;
      pending_q.push_back(e);
    endfunction

    function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] d, logic [2:0] k);
      outcome_t e;
      if (pending_q.size() == 0) begin
        $error("result with no item waiting: tdata 0x%h tuser %0d", d, k);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      results++;
      cmp_field("read_data", e.rdata, d[7:0]);
      cmp_field("updated", {7'd0, e.upd}, {7'd0, d[8]});
      cmp_field("update_mixer", {6'd0, e.mix}, {6'd0, d[10:9]});
      cmp_field("update_source", {3'd0, e.src}, {3'd0, d[15:11]});
      cmp_field("update_meter_slot", {2'd0, e.slot}, {2'd0, d[21:16]});
      cmp_field("index_dropped", {7'd0, e.drop}, {7'd0, d[22]});
      cmp_field("tdata pad", 8'd0, {7'd0, d[23]});
      cmp_field("update_kind", {5'd0, e.kind}, {5'd0, k});
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  parser_scoreboard sb;
  bit idle_on;
  int items_sent;
  int sink_hold = 0;

  dsp_status_message_parser #(
    .MIXERS      (NMIX),
    .SOURCES     (NSRC),
    .METER_SLOTS (NSLOT)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("timeout with %0d results still outstanding", sb.pending_q.size());
    $display("dsp_status_message_parser_test failed");
    $finish;
  end

  // output side: random stall bursts while idling is on
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_axis_tready = 1'b0;
      sink_hold--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready = 1'b0;
      sink_hold = $urandom_range(0, 5);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  function automatic msg_t rand_msg();
    msg_t        m;
    logic [63:0] r;
    r = {$urandom, $urandom};
    m = r[47:0];
    return m;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(logic [1:0] op, msg_t m);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tuser  = op;
    s_axis_tdata  = m;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, m);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_parse(logic [4:0] typ, logic [7:0] val, logic [7:0] b6,
                            logic [7:0] b7);
    msg_t m;
    m = rand_msg();
    m.flag[7:3] = typ;
    m.value = val;
    m.b6 = b6;
    m.b7 = b7;
    send(dspsmp_pkg::OP_PARSE, m);
  endtask

  task automatic read_meter(logic [5:0] slot);
    msg_t m;
    m = rand_msg();
    m.rslot = slot;
    send(dspsmp_pkg::OP_READ_METER, m);
  endtask

  task automatic read_param(logic [2:0] tab, logic [1:0] mix, logic [4:0] src);
    msg_t m;
    m = rand_msg();
    m.rtab = tab;
    m.rmix = mix;
    m.rsrc = src;
    send(dspsmp_pkg::OP_READ_PARAM, m);
  endtask

  // drain every expected result, then let the pipeline idle before returning
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_quirk(bit q);
    cfg_data  = q;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_quirk(q);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_phase(int n);
    int         goal;
    logic [2:0] sel;
    logic [7:0] v;
    logic [4:0] typ;
    goal = items_sent + n;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // mixer select followed by one or two source runs, some past the table end
          sel = 3'(($urandom_range(0, 7) != 0) ? $urandom_range(0, NMIX - 1) :
                                                 $urandom_range(NMIX, 7));
          v = 8'($urandom);
          v[7:5] = sel;
          send_parse(dspsmp_pkg::TYPE_MIXER, v, 8'($urandom), 8'($urandom));
          repeat ($urandom_range(1, 2)) begin
            typ = SRC_TYPES[$urandom_range(0, 4)];
            repeat ($urandom_range(1, 23))
              send_parse(typ, 8'($urandom), 8'($urandom), 8'($urandom));
          end
        end
        5, 6: begin
          repeat ($urandom_range(1, 4))
            send_parse(dspsmp_pkg::TYPE_METER, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        7: begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1))
              read_meter(6'(($urandom_range(0, 3) != 0) ? $urandom_range(0, NSLOT - 1) :
                                                          $urandom_range(0, 63)));
            else if ($urandom_range(0, 3) != 0)
              read_param(3'($urandom_range(0, dspsmp_pkg::TABLES - 1)), 2'($urandom),
                         5'($urandom_range(0, NSRC - 1)));
            else
              read_param(3'($urandom), 2'($urandom), 5'($urandom));
          end
        end
        default: send(2'($urandom_range(0, 3)), rand_msg());
      endcase
    end
  endtask

  initial begin
    sb            = new();
    idle_on       = 1'b0;
    items_sent    = 0;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = dspsmp_pkg::OP_PARSE;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    write_quirk(1'b0);
    idle_on = 1'b1;

    // empty stores, out-of-range reads and the no-op
    read_meter(6'd0);
    read_meter(6'd63);
    read_param(3'd7, 2'd3, 5'd31);
    send(OP_NOP, '1);
    // source messages with no mixer chosen, the second one wraps the counter
    send_parse(dspsmp_pkg::TYPE_GAIN, 8'h12, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_GAIN, 8'h34, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_MIXER, 8'hff, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_MIXER, 8'h60, 8'h00, 8'h00);
    // run of gain carried across the mixer select starts at source one
    send_parse(dspsmp_pkg::TYPE_GAIN, 8'hff, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_PAN, 8'h00, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_FLAG, 8'h5a, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_BALANCE, 8'ha5, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_WIDTH, 8'hff, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_MIXER, 8'h00, 8'h00, 8'h00);
    send_parse(dspsmp_pkg::TYPE_WIDTH, 8'h11, 8'h00, 8'h00);
    // unknown message types
    send_parse(5'h00, 8'hff, 8'hff, 8'hff);
    send_parse(5'h1e, 8'hff, 8'hff, 8'hff);
    // meter index edges of both banks
    send_parse(dspsmp_pkg::TYPE_METER, 8'hff, 8'hff, 8'h00);
    send_parse(dspsmp_pkg::TYPE_METER, 8'h01, 8'h00, 8'h7f);
    send_parse(dspsmp_pkg::TYPE_METER, 8'h02, 8'h00, 8'h80);
    send_parse(dspsmp_pkg::TYPE_METER, 8'h03, 8'h00, 8'h93);
    send_parse(dspsmp_pkg::TYPE_METER, 8'h04, 8'h00, 8'h94);
    send_parse(dspsmp_pkg::TYPE_METER, 8'h05, 8'h00, 8'hff);
    read_param(dspsmp_pkg::TBL_WIDTH, 2'd3, 5'd0);
    read_meter(6'd39);
    settle();

    write_quirk(1'b1);
    send_parse(dspsmp_pkg::TYPE_METER, 8'h77, 8'h85, 8'h00);
    read_meter(6'd25);
    random_phase(300);
    settle();

    write_quirk(1'b0);
    random_phase(300);
    settle();

    write_quirk(1'b1);
    random_phase(300);
    settle();

    // closing stretch with both sides running flat out
    write_quirk(1'b0);
    idle_on = 1'b0;
    random_phase(250);

    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items sent, %0d results checked, %0d reads, %0d dropped indexes",
             items_sent, sb.results, sb.reads, sb.drops);
    $display("stored updates by kind 1..7: %0d %0d %0d %0d %0d %0d %0d, quirk 0 and 1",
             sb.updates[1], sb.updates[2], sb.updates[3], sb.updates[4],
             sb.updates[5], sb.updates[6], sb.updates[7]);
    if (sb.errors == 0)
      $display("dsp_status_message_parser_test passed");
    else
      $display("dsp_status_message_parser_test failed");
    $finish;
  end

endmodule

>>> dsp_status_message_parser.f
hdl/dspsmp_pkg.sv
hdl/dspsmp_store.sv
hdl/dsp_status_message_parser.sv
bench/dsp_status_message_parser_test.sv
